FILE: design/assert_macros.svh
// Assertion macros shared by the parser RTL.
// Each macro expects signals named clock and reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/risp_pkg.sv
// Shared types and constants for the radix integer string parser.
// No dependencies; used by risp_step and radix_integer_string_parser_top.
package risp_pkg;

   // Field widths
   localparam int CharWidth  = 8;
   localparam int RadixWidth = 6;
   localparam int MagWidth   = 64;
   localparam int PhaseWidth = 3;

   // Parse phases
   localparam logic [PhaseWidth-1:0] PH_LEAD        = 3'd0;
   localparam logic [PhaseWidth-1:0] PH_PREFIX      = 3'd1;
   localparam logic [PhaseWidth-1:0] PH_DIGITS      = 3'd2;
   localparam logic [PhaseWidth-1:0] PH_TRAIL_SPACE = 3'd3;
   localparam logic [PhaseWidth-1:0] PH_TRAIL_JUNK  = 3'd4;

   // Register indexes on the csr port
   localparam logic CSR_RADIX  = 1'b0;
   localparam logic CSR_STRICT = 1'b1;

   // Register reset values
   localparam logic [RadixWidth-1:0] RADIX_RESET  = 6'd0;
   localparam logic                  STRICT_RESET = 1'b1;

   // Radix values with special meaning
   localparam logic [RadixWidth-1:0] RADIX_AUTO = 6'd0;
   localparam logic [RadixWidth-1:0] RADIX_MIN  = 6'd2;
   localparam logic [RadixWidth-1:0] RADIX_DEC  = 6'd10;
   localparam logic [RadixWidth-1:0] RADIX_HEX  = 6'd16;
   localparam logic [RadixWidth-1:0] RADIX_MAX  = 6'd36;

   // Input beat
   typedef struct packed {
      logic [CharWidth-1:0] char_byte;
      logic                 has_char;
      logic                 last_byte;
   } risp_req_type;

   // Result beat
   typedef struct packed {
      logic                is_nan;
      logic                negative;
      logic [MagWidth-1:0] magnitude;
      logic                overflowed;
   } risp_rsp_type;

   // Configuration registers
   typedef struct packed {
      logic [RadixWidth-1:0] radix_setting;
      logic                  strict_mode;
   } risp_cfg_type;

   // Per-string parse state
   typedef struct packed {
      logic [PhaseWidth-1:0] phase;
      logic                  sign_flag;
      logic [RadixWidth-1:0] eff_radix;
      logic [MagWidth-1:0]   accumulator;
      logic                  overflow_flag;
      logic                  seen_digit;
      logic                  pending_zero;
      logic                  failed_flag;
   } risp_state_type;

   localparam risp_state_type STATE_RESET = '{
      phase:         PH_LEAD,
      sign_flag:     1'b0,
      eff_radix:     6'd0,
      accumulator:   64'd0,
      overflow_flag: 1'b0,
      seen_digit:    1'b0,
      pending_zero:  1'b0,
      failed_flag:   1'b0
   };

endpackage

FILE: design/risp_step.sv
// Next-state and result logic for one string byte of the parser.
// Depends on risp_pkg.
module risp_step (
   input  risp_pkg::risp_state_type state_cur,
   input  risp_pkg::risp_req_type   item,
   input  risp_pkg::risp_cfg_type   cfg,
   output risp_pkg::risp_state_type state_nxt,
   output risp_pkg::risp_rsp_type   result
);

   localparam int ProdWidth = risp_pkg::MagWidth + risp_pkg::RadixWidth;

   logic [risp_pkg::CharWidth-1:0]  c;
   logic                            is_ws;
   logic                            is_alnum;
   logic [risp_pkg::RadixWidth-1:0] digit_val;
   logic [risp_pkg::RadixWidth-1:0] radix_auto;
   logic                            auto_bad;
   logic                            zero_prefix_ok;

   logic                            enter_prefix;
   logic                            do_digit;
   logic [risp_pkg::RadixWidth-1:0] r_sel;
   logic [risp_pkg::MagWidth-1:0]   acc_sel;
   logic                            ovf_sel;
   logic                            seen_sel;
   logic                            digit_ok;
   logic [ProdWidth-1:0]            prod;
   risp_pkg::risp_state_type        pre;
   risp_pkg::risp_state_type        taken;
   logic                            ok;

   assign c = item.char_byte;

   // ASCII whitespace: space, tab, LF, VT, FF, CR
   assign is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0a) ||
                  (c == 8'h0b) || (c == 8'h0c) || (c == 8'h0d);

   // Digit value, independent of radix
   always_comb begin
      is_alnum  = 1'b1;
      digit_val = '0;
      priority if (c >= "0" && c <= "9") begin
         digit_val = risp_pkg::RadixWidth'(c - "0");
      end else if (c >= "a" && c <= "z") begin
         digit_val = risp_pkg::RadixWidth'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "Z") begin
         digit_val = risp_pkg::RadixWidth'(c - "A" + 8'd10);
      end else begin
         is_alnum = 1'b0;
      end
   end

   assign radix_auto = (cfg.radix_setting == risp_pkg::RADIX_AUTO) ?
                       risp_pkg::RADIX_DEC : cfg.radix_setting;
   assign auto_bad   = (radix_auto < risp_pkg::RADIX_MIN) || (radix_auto > risp_pkg::RADIX_MAX);
   assign zero_prefix_ok = ((cfg.radix_setting == risp_pkg::RADIX_AUTO) ||
                            (cfg.radix_setting == risp_pkg::RADIX_HEX)) && (c == "0");

   // Phase handling; picks the operands of the single digit step
   always_comb begin
      pre          = state_cur;
      enter_prefix = 1'b0;
      do_digit     = 1'b0;
      r_sel        = state_cur.eff_radix;
      acc_sel      = '0;
      ovf_sel      = 1'b0;
      seen_sel     = 1'b0;
      if (item.has_char && !state_cur.failed_flag) begin
         unique case (state_cur.phase)
            risp_pkg::PH_LEAD: begin
               priority if (is_ws) begin
               end else if (c == "-") begin
                  pre.phase     = risp_pkg::PH_PREFIX;
                  pre.sign_flag = 1'b1;
               end else if (c == "+") begin
                  pre.phase = risp_pkg::PH_PREFIX;
               end else begin
                  enter_prefix = 1'b1;
               end
            end
            risp_pkg::PH_PREFIX: begin
               if (state_cur.pending_zero) begin
                  // a leading zero was held back: 0x prefix or digit zero
                  pre.pending_zero = 1'b0;
                  pre.phase        = risp_pkg::PH_DIGITS;
                  if (c == "x" || c == "X") begin
                     pre.eff_radix = risp_pkg::RADIX_HEX;
                  end else begin
                     do_digit = 1'b1;
                     r_sel    = (state_cur.eff_radix == risp_pkg::RADIX_AUTO) ?
                                risp_pkg::RADIX_DEC : state_cur.eff_radix;
                     seen_sel = 1'b1;
                  end
               end else begin
                  enter_prefix = 1'b1;
               end
            end
            risp_pkg::PH_DIGITS: begin
               do_digit = 1'b1;
               acc_sel  = state_cur.accumulator;
               ovf_sel  = state_cur.overflow_flag;
               seen_sel = state_cur.seen_digit;
            end
            risp_pkg::PH_TRAIL_SPACE: begin
               if (!is_ws) pre.phase = risp_pkg::PH_TRAIL_JUNK;
            end
            default: begin
            end
         endcase

         // first byte after whitespace and sign
         if (enter_prefix) begin
            pre.phase = risp_pkg::PH_PREFIX;
            if (zero_prefix_ok) begin
               pre.pending_zero = 1'b1;
               pre.eff_radix    = cfg.radix_setting;
            end else begin
               pre.eff_radix = radix_auto;
               if (auto_bad) begin
                  pre.failed_flag = 1'b1;
               end else begin
                  pre.phase = risp_pkg::PH_DIGITS;
                  do_digit  = 1'b1;
                  r_sel     = radix_auto;
               end
            end
         end
      end
   end

   // Multiply-add of one digit
   assign digit_ok = is_alnum && (digit_val < r_sel);
   assign prod     = ProdWidth'(acc_sel) * ProdWidth'(r_sel) + ProdWidth'(digit_val);

   always_comb begin
      taken = pre;
      if (do_digit) begin
         taken.eff_radix     = r_sel;
         taken.accumulator   = acc_sel;
         taken.overflow_flag = ovf_sel;
         taken.seen_digit    = seen_sel;
         if (digit_ok) begin
            taken.seen_digit = 1'b1;
            if (!ovf_sel) begin
               if (prod[ProdWidth-1:risp_pkg::MagWidth] != '0) begin
                  taken.overflow_flag = 1'b1;
                  taken.accumulator   = '1;
               end else begin
                  taken.accumulator = prod[risp_pkg::MagWidth-1:0];
               end
            end
         end else if (!seen_sel) begin
            taken.failed_flag = 1'b1;
         end else begin
            taken.phase = is_ws ? risp_pkg::PH_TRAIL_SPACE : risp_pkg::PH_TRAIL_JUNK;
         end
      end
   end

   // End-of-string verdict
   always_comb begin
      ok = 1'b0;
      if (!taken.failed_flag) begin
         unique case (taken.phase)
            risp_pkg::PH_PREFIX:      ok = taken.pending_zero;
            risp_pkg::PH_DIGITS:      ok = taken.seen_digit;
            risp_pkg::PH_TRAIL_SPACE: ok = taken.seen_digit;
            risp_pkg::PH_TRAIL_JUNK:  ok = !cfg.strict_mode;
            default:                  ok = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (ok) begin
         result.is_nan     = 1'b0;
         result.negative   = taken.sign_flag;
         result.magnitude  = taken.accumulator;
         result.overflowed = taken.overflow_flag;
      end else begin
         result.is_nan     = 1'b1;
         result.negative   = 1'b0;
         result.magnitude  = '0;
         result.overflowed = 1'b0;
      end
   end

   assign state_nxt = item.last_byte ? risp_pkg::STATE_RESET : taken;

endmodule

FILE: design/radix_integer_string_parser_top.sv
// Top level of the radix integer string parser: input stage, parse state, result register.
// Depends on risp_pkg, risp_step and assert_macros.svh.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | risp_req_type (one string byte)
//   rsp     | out       | rsp_valid/rsp_stall | risp_rsp_type (one result per string)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One byte per clock unless stalled: input register, step logic, state and result registers.
// rsp_valid rises when the result register takes the end-of-string beat's result.
// The 64x6 multiply-add by the radix in risp_step is the long path; it is combinational.
// Synchronous reset clears parse state and both stage valids, and resets the csr registers.
// rsp_stall holds only an end-of-string beat in the input stage; other bytes keep flowing.
// csr_ready is always high.
`include "assert_macros.svh"

module radix_integer_string_parser_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  risp_pkg::risp_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output risp_pkg::risp_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_index,
   input  logic [risp_pkg::RadixWidth-1:0] csr_data
);

   logic                     in_vld_ff, in_vld_in;
   risp_pkg::risp_req_type   in_ff;
   logic                     out_vld_ff, out_vld_in;
   risp_pkg::risp_rsp_type   out_ff;
   risp_pkg::risp_state_type state_ff;
   risp_pkg::risp_state_type state_in;
   risp_pkg::risp_rsp_type   result;
   risp_pkg::risp_cfg_type   cfg_ff;
   logic                     fire;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix_setting <= risp_pkg::RADIX_RESET;
         cfg_ff.strict_mode   <= risp_pkg::STRICT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            risp_pkg::CSR_RADIX:  cfg_ff.radix_setting <= csr_data;
            risp_pkg::CSR_STRICT: cfg_ff.strict_mode   <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   // Input stage advances unless it holds an end-of-string beat and the result slot is busy
   assign fire      = in_vld_ff && (!in_ff.last_byte || !out_vld_ff || !rsp_stall);
   assign req_stall = in_vld_ff && !fire;
   assign in_vld_in = req_stall ? 1'b1 : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
   end

   // Per-byte parse logic
   risp_step u_step (
      .state_cur (state_ff),
      .item      (in_ff),
      .cfg       (cfg_ff),
      .state_nxt (state_in),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= risp_pkg::STATE_RESET;
      end else if (fire) begin
         state_ff <= state_in;
      end
   end

   // Result register
   assign out_vld_in = (fire && in_ff.last_byte) ? 1'b1 : (out_vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_ff.last_byte) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // Checks
   `ASSERT_IMPL(a_nan_clean, rsp_valid && rsp_data.is_nan,
      !rsp_data.negative && (rsp_data.magnitude == '0) && !rsp_data.overflowed,
      "NaN result carries nonzero fields")
   `ASSERT_IMPL(a_ovf_sat, rsp_valid && rsp_data.overflowed, rsp_data.magnitude == '1,
      "overflowed result is not saturated")
   `ASSERT_NEXT(a_end_result, fire && in_ff.last_byte, out_vld_ff,
      "end of string gave no result")
   `ASSERT_NEXT(a_end_clear, fire && in_ff.last_byte,
      (state_ff.phase == risp_pkg::PH_LEAD) && !state_ff.failed_flag && !state_ff.seen_digit,
      "parse state not cleared after end of string")

endmodule
